// ===== rtl/ipp_pkg.sv =====
// ----------------------------------------------------------------------------
// ipp_pkg
// Shared widths, register indexes, the sine table and the serial control type for the
// two-source interference colour generator.
// ----------------------------------------------------------------------------
package ipp_pkg;

    // coordinate width; the coordinate-based datapath widths below follow from it
    localparam int COORD_BITS = 12;
    localparam int CFG_W      = COORD_BITS + 1;     // screen width / height
    localparam int PHASE_W    = 5;
    localparam int CFG_IDX_W  = 1;

    // stream payloads
    localparam int IN_FIELDS_W = 2 * COORD_BITS + PHASE_W;
    localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int COLOR_W     = 8;
    localparam int OUT_W       = 3 * COLOR_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // reset values
    localparam int WIDTH_RST_INT  = 1024;
    localparam int HEIGHT_RST_INT = 768;
    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(WIDTH_RST_INT);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(HEIGHT_RST_INT);
    localparam logic [CFG_W-1:0] S1X_RST    = CFG_W'(WIDTH_RST_INT * 3 / 10);
    localparam logic [CFG_W-1:0] S2X_RST    = CFG_W'(WIDTH_RST_INT * 7 / 10);

    // serial divide-by-ten for the source positions
    localparam int DVD_W     = CFG_W + 3;             // holds width * 7
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int DREM_W    = 4;                     // remainder below ten
    localparam logic [DREM_W:0] DIV_TEN = 5'd10;

    // distance and square root
    localparam int DIFF_W = CFG_W + 1;                // signed x difference
    localparam int DY_W   = COORD_BITS + 1;           // signed y difference
    localparam int SQ_W   = 2 * CFG_W + 1;
    localparam int ROOT_W = CFG_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int CNT_W  = $clog2(ROOT_W);

    // d / 12 = (d >> 2) / 3, the latter by reciprocal (exact below 2^16)
    localparam int DIV3_MUL_W = 16;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 16'd43691;
    localparam int DIV3_SH = 17;
    localparam int PROD_W  = ROOT_W - 2 + DIV3_MUL_W;

    // sine table, amplitude 100
    localparam int WAVE_W = 8;
    localparam logic signed [WAVE_W-1:0] WAVE_TAB [32] = '{
           8'sd0,   8'sd20,   8'sd38,   8'sd56,   8'sd71,   8'sd83,   8'sd92,   8'sd98,
         8'sd100,   8'sd98,   8'sd92,   8'sd83,   8'sd71,   8'sd56,   8'sd38,   8'sd20,
           8'sd0,  -8'sd20,  -8'sd38,  -8'sd56,  -8'sd71,  -8'sd83,  -8'sd92,  -8'sd98,
        -8'sd100,  -8'sd98,  -8'sd92,  -8'sd83,  -8'sd71,  -8'sd56,  -8'sd38,  -8'sd20
    };

    // colour mapping
    localparam int MAG_W = 7;
    localparam logic [COLOR_W-1:0] BLUE_BASE = 8'd40;
    localparam logic [MAG_W-1:0]   RED_KNEE  = 7'd70;
    localparam logic [COLOR_W-1:0] RED_GAIN  = 8'd6;

    // control of a bit- or digit-serial unit
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctl;

endpackage

// ===== rtl/ipp_div10.sv =====
// ----------------------------------------------------------------------------
// ipp_div10
// Bit-serial restoring divide by ten: one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module ipp_div10
    import ipp_pkg::*;
(
    input  logic             i_clk,
    input  t_ser_ctl         i_ctl,
    input  logic [DVD_W-1:0] i_dvd,
    output logic [DVD_W-1:0] o_quot
);

    logic [DVD_W-1:0]  r_dvd;
    logic [DREM_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_quot;

    logic [DREM_W:0]   w_cur;
    logic              w_take;
    logic [DREM_W:0]   w_diff;

    assign w_cur  = {r_rem, r_dvd[DVD_W-1]};
    assign w_take = (w_cur >= DIV_TEN);
    assign w_diff = w_cur - DIV_TEN;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= i_dvd;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem  <= w_take ? w_diff[DREM_W-1:0] : w_cur[DREM_W-1:0];
            r_quot <= {r_quot[DVD_W-2:0], w_take};
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== rtl/ipp_root.sv =====
// ----------------------------------------------------------------------------
// ipp_root
// Digit-serial floor square root: two radicand bits in, one root bit out
// per step.
// ----------------------------------------------------------------------------
module ipp_root
    import ipp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ser_ctl          i_ctl,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  w_cur;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_take;

    // partial remainder with the next radicand pair, against 4q+1
    assign w_cur   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_take  = (w_cur >= w_trial);
    assign w_diff  = w_cur - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rad <= i_rad;
        end else if (i_ctl.step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.load) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            r_rem  <= w_take ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_take};
        end
    end

    assign o_root = r_root;

    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= {r_root, 1'b0})
        else $error("root remainder out of bound");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |=> (r_root == '0) && (r_rem == '0))
        else $error("root load did not clear");

    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.load && i_ctl.step))
        else $error("root load and step together");

endmodule

// ===== rtl/interference_pattern_pixel.sv =====
// ----------------------------------------------------------------------------
// interference_pattern_pixel
// Two-source radial interference colour: pixel and frame phase in,
// 24-bit RGB out.
// ----------------------------------------------------------------------------
// One item is a pixel coordinate and a frame phase; it gives one colour item.
// An item runs through the source offsets, the squares, the square roots
// (two radicand bits a cycle, both sources side by side), the ring index and
// sine look-up and the colour, then goes back to idle, where the next item is
// taken; no new item is taken before then. Most of an item's time goes to the
// 14-step root loop. A finished colour waits in an output register, so the
// next item is taken while it is still unclaimed. A write to screen_width
// recomputes both source positions with a bit-serial divide by ten; input is
// held off until both new positions are stored. screen_height is used
// directly.
// ----------------------------------------------------------------------------
module interference_pattern_pixel
    import ipp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_W-1:0]      i_s_axis_tdata,   // pixel_x, pixel_y, frame_phase, zero pad
    // result items
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,   // color (blue 7..0, green 15..8, red 23..16)
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIFF  = 6'b000010,
        S_SQ    = 6'b000100,
        S_ROOT  = 6'b001000,
        S_WAVE  = 6'b010000,
        S_SHADE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration and derived source positions
    logic [CFG_W-1:0]     r_height;
    logic [CFG_W-1:0]     r_s1x, r_s2x;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_fin;
    t_ser_ctl             w_div_ctl;
    logic [DVD_W-1:0]     w_dvd3, w_dvd7, w_quot1, w_quot2;

    // item payload
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [PHASE_W-1:0]    r_phase;
    logic [CFG_W-1:0]      r_dx1, r_dx2;
    logic [COORD_BITS-1:0] r_dy;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [WAVE_W-1:0] r_wave_a, r_wave_b;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_color;

    logic w_s_ready, w_in_acc, w_out_free;

    // ---- handshake ----
    assign w_s_ready  = (r_state == S_IDLE) && (r_div_cnt == '0) && !r_div_fin;
    assign w_in_acc   = i_s_axis_tvalid && w_s_ready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = w_s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_color;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_DIFF;
            S_DIFF:  n_state = S_SQ;
            S_SQ:    n_state = S_ROOT;
            S_ROOT:  if (r_cnt == '0) n_state = S_WAVE;
            S_WAVE:  n_state = S_SHADE;
            S_SHADE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- source positions: x = width*3/10 and width*7/10, serially ----
    assign w_div_ctl.load = i_cfg_we && (i_cfg_addr == REG_SCREEN_WIDTH);
    assign w_div_ctl.step = (r_div_cnt != '0);
    assign w_dvd3 = DVD_W'(i_cfg_data) * DVD_W'(3);
    assign w_dvd7 = DVD_W'(i_cfg_data) * DVD_W'(7);

    ipp_div10 u_div_s1 (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_dvd  (w_dvd3),
        .o_quot (w_quot1)
    );

    ipp_div10 u_div_s2 (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_dvd  (w_dvd7),
        .o_quot (w_quot2)
    );

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_height    <= HEIGHT_RST;
            r_s1x       <= S1X_RST;
            r_s2x       <= S2X_RST;
            r_div_cnt   <= '0;
            r_div_fin   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // a width write only feeds the dividers
            if (i_cfg_we && (i_cfg_addr == REG_SCREEN_HEIGHT)) begin
                r_height <= i_cfg_data;
            end

            if (w_div_ctl.load) begin
                r_div_cnt <= DIV_CNT_W'(DVD_W);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            r_div_fin <= (r_div_cnt == DIV_CNT_W'(1)) && !w_div_ctl.load;
            if (r_div_fin) begin
                r_s1x <= w_quot1[CFG_W-1:0];
                r_s2x <= w_quot2[CFG_W-1:0];
            end

            if ((r_state == S_SHADE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- offsets from the sources ----
    logic [COORD_BITS-1:0] w_sy;
    logic [DIFF_W-1:0]     w_d1, w_d2;
    logic [DY_W-1:0]       w_dyv;

    assign w_sy  = r_height[CFG_W-1:1];
    assign w_d1  = DIFF_W'(r_px) - DIFF_W'(r_s1x);
    assign w_d2  = DIFF_W'(r_px) - DIFF_W'(r_s2x);
    assign w_dyv = DY_W'(r_py) - DY_W'(w_sy);

    // ---- squared distances into the root units ----
    logic [2*CFG_W-1:0]      w_dx1_sq, w_dx2_sq;
    logic [2*COORD_BITS-1:0] w_dy_sq;
    logic [SQ_W-1:0]         w_sq1, w_sq2;
    t_ser_ctl                w_root_ctl;
    logic [ROOT_W-1:0]       w_root1, w_root2;

    assign w_dx1_sq = (2*CFG_W)'(r_dx1) * (2*CFG_W)'(r_dx1);
    assign w_dx2_sq = (2*CFG_W)'(r_dx2) * (2*CFG_W)'(r_dx2);
    assign w_dy_sq  = (2*COORD_BITS)'(r_dy) * (2*COORD_BITS)'(r_dy);
    assign w_sq1    = SQ_W'(w_dx1_sq) + SQ_W'(w_dy_sq);
    assign w_sq2    = SQ_W'(w_dx2_sq) + SQ_W'(w_dy_sq);

    assign w_root_ctl.load = (r_state == S_SQ);
    assign w_root_ctl.step = (r_state == S_ROOT);

    ipp_root u_root1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_root_ctl),
        .i_rad   (RAD_W'(w_sq1)),
        .o_root  (w_root1)
    );

    ipp_root u_root2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_root_ctl),
        .i_rad   (RAD_W'(w_sq2)),
        .o_root  (w_root2)
    );

    // ---- ring index: (d/12 - phase) mod 32 ----
    logic [PROD_W-1:0]  w_prod1, w_prod2;
    logic [PHASE_W-1:0] w_idx1, w_idx2;

    assign w_prod1 = PROD_W'(w_root1[ROOT_W-1:2]) * PROD_W'(DIV3_MUL);
    assign w_prod2 = PROD_W'(w_root2[ROOT_W-1:2]) * PROD_W'(DIV3_MUL);
    assign w_idx1  = w_prod1[DIV3_SH +: PHASE_W] - r_phase;
    assign w_idx2  = w_prod2[DIV3_SH +: PHASE_W] - r_phase;

    // ---- colour: average toward zero, magnitude, ramps ----
    logic [WAVE_W:0]      w_sum, w_half, w_avg, w_abs;
    logic [MAG_W-1:0]     w_m, w_mr;
    logic [COLOR_W-1:0]   w_m2, w_red, w_green, w_blue;

    assign w_sum   = {r_wave_a[WAVE_W-1], r_wave_a} + {r_wave_b[WAVE_W-1], r_wave_b};
    assign w_half  = w_sum + {{WAVE_W{1'b0}}, w_sum[WAVE_W]};   // bias negatives
    assign w_avg   = {w_half[WAVE_W], w_half[WAVE_W:1]};
    assign w_abs   = w_avg[WAVE_W] ? (~w_avg + (WAVE_W+1)'(1)) : w_avg;
    assign w_m     = w_abs[MAG_W-1:0];
    assign w_m2    = {w_m, 1'b0};
    assign w_mr    = w_m - RED_KNEE;
    assign w_blue  = w_m2 + BLUE_BASE;
    assign w_green = w_m2;
    assign w_red   = (w_m > RED_KNEE) ? (COLOR_W'(w_mr) * RED_GAIN) : '0;

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px    <= i_s_axis_tdata[COORD_BITS-1:0];
            r_py    <= i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            r_phase <= i_s_axis_tdata[2*COORD_BITS +: PHASE_W];
        end
        if (r_state == S_DIFF) begin
            r_dx1 <= w_d1[DIFF_W-1] ? CFG_W'(-w_d1) : w_d1[CFG_W-1:0];
            r_dx2 <= w_d2[DIFF_W-1] ? CFG_W'(-w_d2) : w_d2[CFG_W-1:0];
            r_dy  <= w_dyv[DY_W-1] ? COORD_BITS'(-w_dyv) : w_dyv[COORD_BITS-1:0];
        end
        if (r_state == S_SQ) begin
            r_cnt <= CNT_W'(ROOT_W - 1);
        end else if ((r_state == S_ROOT) && (r_cnt != '0)) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (r_state == S_WAVE) begin
            r_wave_a <= WAVE_TAB[w_idx1];
            r_wave_b <= WAVE_TAB[w_idx2];
        end
        if ((r_state == S_SHADE) && w_out_free) begin
            r_color <= {w_red, w_green, w_blue};
        end
    end

    // ---- checks ----
    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_div_cnt != '0) || r_div_fin) |-> !o_s_axis_tready)
        else $error("item taken during source recompute");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIFF))
        else $error("accepted item not started");

    a_root_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ROOT) && (r_cnt == '0)) |=> (r_state == S_WAVE))
        else $error("root loop overran");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_SHADE))
        else $error("result raised outside colour stage");

endmodule
